[src/gcd_pkg.sv]
// shared types, constants and arithmetic helpers for the great-circle distance pipeline
package gcd_pkg;

  localparam int CordicStepsDef = 28;
  localparam int SqrtSteps      = 32;

  localparam logic [31:0] DegToRadQ60 = 32'd2012227627;
  localparam logic signed [63:0] CordicGainQ30 = 64'sd652032874;
  localparam logic signed [63:0] PiQ29         = 64'sd1686629713;
  localparam logic signed [63:0] HalfPiQ29     = 64'sd843314857;
  localparam logic [24:0] MaxDistanceM = 25'd20015087;
  localparam logic [22:0] EarthRadiusM = 23'd6371000;
  localparam logic [63:0] OneQ60 = 64'h1000_0000_0000_0000;

  typedef logic signed [63:0] word_t;

  // sin/cos lane: angle, x, y, cosine flip
  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
    logic  flip;
  } rot_t;

  // per-item payload travelling beside the arithmetic
  typedef struct packed {
    logic vld;
    logic known;
  } tag_t;

  function automatic word_t atan_step(input int i);
    word_t r;
    r = '0;
    case (i)
      0: r = 64'sd421657428;
      1: r = 64'sd248918915;
      2: r = 64'sd131521918;
      3: r = 64'sd66762579;
      4: r = 64'sd33510843;
      5: r = 64'sd16771758;
      6: r = 64'sd8387925;
      7: r = 64'sd4194219;
      8: r = 64'sd2097141;
      9: r = 64'sd1048575;
      default: begin
        if (i < 30) r = word_t'(64'sd1 <<< (29 - i));
        else r = '0;
      end
    endcase
    return r;
  endfunction

endpackage

[src/great_circle_distance_core.sv]
// top level: haversine distance pipeline built from chains of cordic and square-root cells
//
//   channel | direction | ports
//   in      | request   | in_valid, in_ready, in_uav_lat .. in_uav_known
//   out     | result    | out_valid, out_ready, out_distance_m, out_distance_valid
//
// one request per cycle while the output is not stalled; the path runs through the
// two cordic chains, the 32-cell square root and the multiplier stages.
// the whole pipeline advances only when its last stage is empty or taken, so
// a stalled output freezes every stage; reset clears the stage valid bits.
module great_circle_distance_core #(
  parameter int CORDIC_STEPS = gcd_pkg::CordicStepsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [30:0] in_uav_lat,
  input  logic signed [31:0] in_uav_lon,
  input  logic signed [30:0] in_pilot_lat,
  input  logic signed [31:0] in_pilot_lon,
  input  logic               in_pilot_known,
  input  logic               in_uav_known,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [24:0]        out_distance_m,
  output logic               out_distance_valid
);
  import gcd_pkg::*;

  localparam int NStages = 2 * CORDIC_STEPS + 42;

  // tag shift line: stage valid and known flag
  tag_t tag_r [NStages+1];
  logic en;

  assign en        = !tag_r[NStages].vld || out_ready;
  assign in_ready  = en;
  assign out_valid = tag_r[NStages].vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NStages; k++) tag_r[k] <= '0;
    end else if (en) begin
      tag_r[0].vld   <= in_valid;
      tag_r[0].known <= in_pilot_known & in_uav_known;
      for (int k = 1; k <= NStages; k++) tag_r[k] <= tag_r[k-1];
    end
  end

  // stage 1: differences, magnitudes
  logic [32:0] mag_r [4];
  logic        neg_r [4];
  logic signed [32:0] dv [4];

  always_comb begin
    dv[0] = 33'(in_pilot_lat) - 33'(in_uav_lat);
    dv[1] = 33'(in_pilot_lon) - 33'(in_uav_lon);
    dv[2] = 33'(in_uav_lat);
    dv[3] = 33'(in_pilot_lat);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        neg_r[k] <= dv[k][32];
        mag_r[k] <= dv[k][32] ? 33'(-dv[k]) : 33'(dv[k]);
      end
    end
  end

  // stage 2: multiply by deg-to-rad
  logic [64:0] prod_r [4];
  logic        neg2_r [4];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        prod_r[k] <= 65'(mag_r[k]) * 65'(DegToRadQ60);
        neg2_r[k] <= neg_r[k];
      end
    end
  end

  // stage 3: round, sign, reflect into +-pi/2
  rot_t lane [4][CORDIC_STEPS+1];

  for (genvar k = 0; k < 4; k++) begin : g_pre
    logic [63:0] rr;
    word_t       ang;

    always_comb begin
      if (k < 2) rr = 64'((prod_r[k] + 65'(64'd1 << 31)) >> 32);
      else rr = 64'((prod_r[k] + 65'(64'd1 << 30)) >> 31);
      ang = neg2_r[k] ? -word_t'(rr) : word_t'(rr);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        lane[k][0].x <= CordicGainQ30;
        lane[k][0].y <= '0;
        if (ang > HalfPiQ29) begin
          lane[k][0].z    <= PiQ29 - ang;
          lane[k][0].flip <= 1'b1;
        end else if (ang < -HalfPiQ29) begin
          lane[k][0].z    <= -PiQ29 - ang;
          lane[k][0].flip <= 1'b1;
        end else begin
          lane[k][0].z    <= ang;
          lane[k][0].flip <= 1'b0;
        end
      end
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_lane
    for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_cell
      gcd_rot_cell #(.STEP(s)) u_cell (
        .clk(clk), .en(en), .d_in(lane[k][s]), .d_out(lane[k][s+1])
      );
    end
  end

  // products: sines and cosines fit in 32 bits
  logic signed [31:0] s1, s2, c1, c2;
  assign s1 = lane[0][CORDIC_STEPS].y[31:0];
  assign s2 = lane[1][CORDIC_STEPS].y[31:0];
  assign c1 = lane[2][CORDIC_STEPS].flip ? -lane[2][CORDIC_STEPS].x[31:0]
                                         : lane[2][CORDIC_STEPS].x[31:0];
  assign c2 = lane[3][CORDIC_STEPS].flip ? -lane[3][CORDIC_STEPS].x[31:0]
                                         : lane[3][CORDIC_STEPS].x[31:0];

  word_t sq_r, sq2_r, a_r, sq3_r, ts_r;
  logic signed [31:0] cc_r, s2a_r, t_r, s2b_r;
  word_t ccp, tp;

  assign ccp = c1 * c2;
  assign tp  = cc_r * s2a_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r  <= s1 * s1;
      cc_r  <= ccp[61:30];
      s2a_r <= s2;
      sq2_r <= sq_r;
      t_r   <= tp[61:30];
      s2b_r <= s2a_r;
      sq3_r <= sq2_r;
      ts_r  <= t_r * s2b_r;
      a_r   <= sq3_r + ts_r;
    end
  end

  logic [63:0] ac;
  assign ac = a_r[63] ? '0 : ((a_r > word_t'(OneQ60)) ? OneQ60 : a_r[63:0]);

  logic [63:0] va [SqrtSteps+1];
  logic [63:0] ra [SqrtSteps+1];
  logic [63:0] vb [SqrtSteps+1];
  logic [63:0] rb [SqrtSteps+1];

  always_ff @(posedge clk) begin
    if (en) begin
      va[0] <= ac;
      vb[0] <= OneQ60 - ac;
      ra[0] <= '0;
      rb[0] <= '0;
    end
  end

  for (genvar s = 0; s < SqrtSteps; s++) begin : g_sqrt
    gcd_sqrt_cell #(.STEP(s)) u_cell (
      .clk(clk), .en(en),
      .va_in(va[s]), .ra_in(ra[s]), .vb_in(vb[s]), .rb_in(rb[s]),
      .va_out(va[s+1]), .ra_out(ra[s+1]), .vb_out(vb[s+1]), .rb_out(rb[s+1])
    );
  end

  rot_t vec [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      vec[0].y    <= ra[SqrtSteps];
      vec[0].x    <= rb[SqrtSteps];
      vec[0].z    <= '0;
      vec[0].flip <= 1'b0;
    end
  end

  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_vec
    gcd_vec_cell #(.STEP(s)) u_cell (
      .clk(clk), .en(en), .d_in(vec[s]), .d_out(vec[s+1])
    );
  end

  logic [63:0] dm_r;
  logic [24:0] dist_r;
  word_t zf;
  logic [63:0] dr;
  assign zf = vec[CORDIC_STEPS].z[63] ? '0 : vec[CORDIC_STEPS].z;
  assign dr = (dm_r + (64'd1 << 27)) >> 28;

  always_ff @(posedge clk) begin
    if (en) begin
      dm_r   <= zf[31:0] * EarthRadiusM;
      dist_r <= (dr > 64'(MaxDistanceM)) ? MaxDistanceM : dr[24:0];
    end
  end

  assign out_distance_m     = tag_r[NStages].known ? dist_r : '0;
  assign out_distance_valid = tag_r[NStages].known;
endmodule

[src/gcd_rot_cell.sv]
// one rotation-mode cordic cell, instantiated in each of the four sin/cos lanes
module gcd_rot_cell #(
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          en,
  input  gcd_pkg::rot_t d_in,
  output gcd_pkg::rot_t d_out
);
  import gcd_pkg::*;

  rot_t nxt;

  always_comb begin
    nxt = d_in;
    if (d_in.z >= 0) begin
      nxt.x = d_in.x - (d_in.y >>> STEP);
      nxt.y = d_in.y + (d_in.x >>> STEP);
      nxt.z = d_in.z - atan_step(STEP);
    end else begin
      nxt.x = d_in.x + (d_in.y >>> STEP);
      nxt.y = d_in.y - (d_in.x >>> STEP);
      nxt.z = d_in.z + atan_step(STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (en) d_out <= nxt;
  end
endmodule

[src/gcd_vec_cell.sv]
// one vectoring-mode cordic cell of the atan2 chain
module gcd_vec_cell #(
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          en,
  input  gcd_pkg::rot_t d_in,
  output gcd_pkg::rot_t d_out
);
  import gcd_pkg::*;

  rot_t nxt;

  always_comb begin
    nxt = d_in;
    if (d_in.y >= 0) begin
      nxt.x = d_in.x + (d_in.y >>> STEP);
      nxt.y = d_in.y - (d_in.x >>> STEP);
      nxt.z = d_in.z + atan_step(STEP);
    end else begin
      nxt.x = d_in.x - (d_in.y >>> STEP);
      nxt.y = d_in.y + (d_in.x >>> STEP);
      nxt.z = d_in.z - atan_step(STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (en) d_out <= nxt;
  end
endmodule

[src/gcd_sqrt_cell.sv]
// one restoring square-root cell, two radicands side by side
module gcd_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] va_in,
  input  logic [63:0] ra_in,
  input  logic [63:0] vb_in,
  input  logic [63:0] rb_in,
  output logic [63:0] va_out,
  output logic [63:0] ra_out,
  output logic [63:0] vb_out,
  output logic [63:0] rb_out
);
  localparam logic [63:0] Bit = 64'd1 << (62 - 2 * STEP);

  logic [63:0] va_nxt, ra_nxt, vb_nxt, rb_nxt;

  always_comb begin
    if (va_in >= ra_in + Bit) begin
      va_nxt = va_in - (ra_in + Bit);
      ra_nxt = (ra_in >> 1) + Bit;
    end else begin
      va_nxt = va_in;
      ra_nxt = ra_in >> 1;
    end
    if (vb_in >= rb_in + Bit) begin
      vb_nxt = vb_in - (rb_in + Bit);
      rb_nxt = (rb_in >> 1) + Bit;
    end else begin
      vb_nxt = vb_in;
      rb_nxt = rb_in >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      va_out <= va_nxt;
      ra_out <= ra_nxt;
      vb_out <= vb_nxt;
      rb_out <= rb_nxt;
    end
  end
endmodule

[tb/tb_top.sv]
// testbench for the great-circle distance core: directed and random requests checked against a local predictor
`timescale 1ns / 1ps

module tb_top;
  import gcd_pkg::*;

  localparam int Steps = CordicStepsDef;
  localparam int Latency = 2 * Steps + 42;
  localparam int StallLimit = 20000;

  typedef struct {
    logic [24:0] distance;
    logic        vld;
  } dist_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [30:0] in_uav_lat;
  logic signed [31:0] in_uav_lon;
  logic signed [30:0] in_pilot_lat;
  logic signed [31:0] in_pilot_lon;
  logic               in_pilot_known;
  logic               in_uav_known;
  logic               out_valid;
  logic               out_ready;
  logic [24:0]        out_distance_m;
  logic               out_distance_valid;

  dist_result_t pending_dist[$];
  int  mismatches;
  int  n_requests;
  int  n_results;
  int  n_valid_results;
  int  idle_cycles;
  bit  idling_on;
  bit  hold_results;

  great_circle_distance_core #(.CORDIC_STEPS(Steps)) DUT (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // fixed-point haversine
  function automatic longint deg7_to_rad(longint deg7, int sh);
    longint unsigned mag;
    longint unsigned r;
    mag = (deg7 < 0) ? longint'(-deg7) : deg7;
    r = (mag * 64'd2012227627 + (64'd1 << (sh - 1))) >> sh;
    return (deg7 < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic void cordic_sin_cos(input longint ang, output longint sn,
                                         output longint cs);
    longint x, y, z, dx, dy;
    bit flip;
    flip = 0;
    x = CordicGainQ30;
    y = 0;
    if (ang > HalfPiQ29) begin
      ang = PiQ29 - ang;
      flip = 1;
    end else if (ang < -HalfPiQ29) begin
      ang = -PiQ29 - ang;
      flip = 1;
    end
    z = ang;
    for (int i = 0; i < Steps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    sn = y;
    cs = flip ? -x : x;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    for (int k = 0; k < 32; k++) begin
      bitv = 64'd1 << (62 - 2 * k);
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
    end
    return res;
  endfunction

  function automatic longint cordic_atan2(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < Steps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_step(i);
      end else begin
        x -= dx; y += dy; z -= atan_step(i);
      end
    end
    return z;
  endfunction

  function automatic dist_result_t predict_distance(longint lat1, longint lon1, longint lat2,
                                                    longint lon2, bit pk, bit uk);
    dist_result_t r;
    longint s1, s2, c1, c2, dummy, cc, t, a, z;
    longint unsigned d;
    r.distance = '0;
    r.vld = 1'b0;
    if (!(pk && uk)) return r;
    cordic_sin_cos(deg7_to_rad(lat2 - lat1, 32), s1, dummy);
    cordic_sin_cos(deg7_to_rad(lon2 - lon1, 32), s2, dummy);
    cordic_sin_cos(deg7_to_rad(lat1, 31), dummy, c1);
    cordic_sin_cos(deg7_to_rad(lat2, 31), dummy, c2);
    cc = (c1 * c2) >>> 30;
    t = (cc * s2) >>> 30;
    a = s1 * s1 + t * s2;
    if (a < 0) a = 0;
    if (a > longint'(OneQ60)) a = OneQ60;
    z = cordic_atan2(longint'(root_floor(a)), longint'(root_floor(OneQ60 - a)));
    if (z < 0) z = 0;
    d = (longint'(z) * 64'd6371000 + (64'd1 << 27)) >> 28;
    if (d > MaxDistanceM) d = MaxDistanceM;
    r.distance = d[24:0];
    r.vld = 1'b1;
    return r;
  endfunction

  task automatic send_request(longint ulat, longint ulon, longint plat, longint plon,
                              bit pk, bit uk);
    int gap;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_uav_lat = ulat[30:0];
    in_uav_lon = ulon[31:0];
    in_pilot_lat = plat[30:0];
    in_pilot_lon = plon[31:0];
    in_pilot_known = pk;
    in_uav_known = uk;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_dist.push_back(predict_distance(longint'(in_uav_lat), longint'(in_uav_lon),
                                            longint'(in_pilot_lat), longint'(in_pilot_lon),
                                            pk, uk));
    n_requests++;
  endtask

  function automatic longint rand_lat();
    return longint'($urandom_range(0, 1800000000)) - 900000000;
  endfunction

  function automatic longint rand_lon();
    return longint'($urandom_range(0, 32'd3600000000)) - 1800000000;
  endfunction

  function automatic longint clip(longint v, longint lim);
    return (v > lim) ? lim : ((v < -lim) ? -lim : v);
  endfunction

  task automatic send_random(int n);
    longint la, lo;
    for (int i = 0; i < n; i++) begin
      la = rand_lat();
      lo = rand_lon();
      case ($urandom_range(0, 9))
        0, 1, 2, 3:
          send_request(la, lo, clip(la + $urandom_range(0, 200000) - 100000, 900000000),
                       clip(lo + $urandom_range(0, 200000) - 100000, 1800000000), 1, 1);
        4, 5, 6:
          send_request(la, lo, rand_lat(), rand_lon(), 1, 1);
        7:
          send_request(la, lo, -la, (lo >= 0) ? lo - 1800000000 : lo + 1800000000, 1, 1);
        8:
          send_request(la, lo, la, lo, 1, $urandom_range(0, 1));
        default:
          send_request(la, lo, rand_lat(), rand_lon(), $urandom_range(0, 1),
                       $urandom_range(0, 1));
      endcase
    end
  endtask

  task automatic test_unknown_positions();
    send_request(100000000, 200000000, -300000000, 400000000, 0, 1);
    send_request(100000000, 200000000, -300000000, 400000000, 1, 0);
    send_request(900000000, 1800000000, -900000000, -1800000000, 0, 0);
  endtask

  task automatic test_extremes();
    send_request(0, 0, 0, 0, 1, 1);
    send_request(0, 0, 0, 1, 1, 1);
    send_request(0, 0, 1, 0, 1, 1);
    send_request(0, 0, 0, 1800000000, 1, 1);
    send_request(0, -1800000000, 0, 1800000000, 1, 1);
    send_request(900000000, 0, -900000000, 0, 1, 1);
    send_request(-900000000, 0, 900000000, 1800000000, 1, 1);
    send_request(900000000, 1800000000, 900000000, -1800000000, 1, 1);
    send_request(-900000000, -1800000000, 900000000, 1800000000, 1, 1);
    send_request(450000000, 1799999999, 450000000, -1799999999, 1, 1);
    send_request(0, 900000000, 0, -900000000, 1, 1);
    send_request(0, 1000000000, 0, -1000000000, 1, 1);
    send_request(899999999, 1, -899999999, -1, 1, 1);
    send_request(-1, -1, 1, 1, 1, 1);
    send_request(123456789, -987654321, -123456789, 987654321, 1, 1);
  endtask

  task automatic test_random_traffic(int n);
    idling_on = 1'b1;
    send_random(n);
  endtask

  task automatic test_output_backpressure();
    hold_results = 1'b1;
    send_random(Latency + 60);
    hold_results = 1'b0;
  endtask

  task automatic test_full_rate(int n);
    idling_on = 1'b0;
    send_random(n);
  endtask

  // result side: bursty ready, long hold on request
  initial begin
    int burst;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_results) begin
        out_ready = 1'b0;
        burst = 0;
        while (hold_results && burst < 400) begin
          @(negedge clk);
          burst++;
        end
        out_ready = 1'b1;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 12);
        out_ready = 1'b0;
        repeat (burst - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    dist_result_t exp_r;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, StallLimit);
        $display("Regression FAIL");
        $finish;
      end
      if (out_valid && out_ready) begin
        n_results++;
        if (pending_dist.size() == 0) begin
          $display("%0t: unexpected result dist=%0d valid=%0b", $time, out_distance_m,
                   out_distance_valid);
          mismatches++;
        end else begin
          exp_r = pending_dist.pop_front();
          if (exp_r.vld) n_valid_results++;
          if (out_distance_m !== exp_r.distance) begin
            $display("%0t: distance_m expected %0d actual %0d", $time, exp_r.distance,
                     out_distance_m);
            mismatches++;
          end
          if (out_distance_valid !== exp_r.vld) begin
            $display("%0t: distance_valid expected %0b actual %0b", $time, exp_r.vld,
                     out_distance_valid);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_uav_lat = '0;
    in_uav_lon = '0;
    in_pilot_lat = '0;
    in_pilot_lon = '0;
    in_pilot_known = 1'b0;
    in_uav_known = 1'b0;
    mismatches = 0;
    n_requests = 0;
    n_results = 0;
    n_valid_results = 0;
    idle_cycles = 0;
    idling_on = 1'b0;
    hold_results = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_unknown_positions();
    test_extremes();
    test_random_traffic(1300);
    test_output_backpressure();
    test_random_traffic(200);
    test_full_rate(300);

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_dist.size() != 0) @(posedge clk);
    repeat (Latency + 20) @(posedge clk);

    $display("sent %0d requests (directed extremes, unknown flags, near, far, antipodal)",
             n_requests);
    $display("checked %0d results, %0d with valid distance, %0d mismatches", n_results,
             n_valid_results, mismatches);
    if (mismatches == 0 && pending_dist.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
src/gcd_pkg.sv
src/gcd_rot_cell.sv
src/gcd_vec_cell.sv
src/gcd_sqrt_cell.sv
src/great_circle_distance_core.sv
tb/tb_top.sv
